// ===== src/i2cbs_pkg.sv =====
package i2cbs_pkg;

    // Request codes carried in the req_type field of an input word.
    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_WRITE = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    // Phase numbers that mark the end of each part of a sequence.
    localparam logic [4:0] WR_DATA_PHASES = 5'd24;
    localparam logic [4:0] WR_ACK_SETUP   = 5'd24;
    localparam logic [4:0] WR_ACK_SAMPLE  = 5'd25;
    localparam logic [4:0] RD_DATA_PHASES = 5'd16;
    localparam logic [4:0] RD_ACK_SETUP   = 5'd16;
    localparam logic [4:0] RD_ACK_HIGH    = 5'd17;

    // Position within one three-phase bit slot of a write.
    localparam logic [1:0] SUB_SETUP = 2'd0;
    localparam logic [1:0] SUB_HIGH  = 2'd1;
    localparam logic [1:0] SUB_LOW   = 2'd2;

    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_level;
    } t_in_word;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic       nack_seen;
        logic [7:0] read_byte;
    } t_out_word;

endpackage

// ===== src/i2cbs_core.sv =====
module i2cbs_core
    import i2cbs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_word  i_word,
    output t_out_word o_res
);

    t_op        r_op,    n_op;
    logic [4:0] r_phase, n_phase;
    logic [1:0] r_sub,   n_sub;
    logic [7:0] r_tx,    n_tx;
    logic [7:0] r_rx,    n_rx;
    logic       r_ack,   n_ack;
    logic       r_nack,  n_nack;
    logic       r_scl,   n_scl;
    logic       r_sda,   n_sda;
    logic       last;
    logic       done;
    logic       is_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= OP_IDLE;
            r_phase <= '0;
            r_sub   <= SUB_SETUP;
            r_tx    <= '0;
            r_rx    <= '0;
            r_ack   <= 1'b0;
            r_nack  <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b0;
        end else if (i_fire) begin
            r_op    <= n_op;
            r_phase <= n_phase;
            r_sub   <= n_sub;
            r_tx    <= n_tx;
            r_rx    <= n_rx;
            r_ack   <= n_ack;
            r_nack  <= n_nack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
        end
    end

    always_comb begin
        n_op    = r_op;
        n_phase = r_phase;
        n_sub   = r_sub;
        n_tx    = r_tx;
        n_rx    = r_rx;
        n_ack   = r_ack;
        n_nack  = r_nack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        last    = 1'b0;
        done    = 1'b0;
        is_cmd  = (i_word.req_type >= REQ_START) && (i_word.req_type <= REQ_READ);

        if (is_cmd) begin
            // A command is taken only while idle; otherwise it is dropped.
            if (r_op == OP_IDLE) begin
                n_op    = t_op'(i_word.req_type);
                n_phase = '0;
                n_sub   = SUB_SETUP;
                if (i_word.req_type == REQ_WRITE) begin
                    n_tx = i_word.tx_byte;
                end
                if (i_word.req_type == REQ_READ) begin
                    n_ack = i_word.send_ack;
                    n_rx  = '0;
                end
            end
        end else if (i_word.req_type == REQ_TICK && r_op != OP_IDLE) begin
            unique case (r_op)
                OP_START: begin
                    if (r_phase == 5'd0) begin
                        n_scl = 1'b1;
                        n_sda = 1'b0;
                    end else if (r_phase == 5'd1) begin
                        n_sda = 1'b1;
                    end else begin
                        n_scl = 1'b0;
                        last  = 1'b1;
                    end
                end
                OP_STOP: begin
                    if (r_phase == 5'd0) begin
                        n_scl = 1'b0;
                        n_sda = 1'b1;
                    end else if (r_phase == 5'd1) begin
                        n_scl = 1'b1;
                    end else begin
                        n_sda = 1'b0;
                        last  = 1'b1;
                    end
                end
                OP_WRITE: begin
                    if (r_phase < WR_DATA_PHASES) begin
                        unique case (r_sub)
                            SUB_SETUP: begin
                                n_scl = 1'b0;
                                n_sda = ~r_tx[7];
                            end
                            SUB_HIGH: begin
                                n_scl = 1'b1;
                            end
                            default: begin
                                n_scl = 1'b0;
                                n_tx  = {r_tx[6:0], 1'b0};
                            end
                        endcase
                    end else if (r_phase == WR_ACK_SETUP) begin
                        n_scl = 1'b0;
                        n_sda = 1'b0;
                    end else if (r_phase == WR_ACK_SAMPLE) begin
                        // The slave's ack is sampled while SCL is high.
                        n_scl  = 1'b1;
                        n_nack = i_word.sda_level;
                    end else begin
                        n_scl = 1'b0;
                        last  = 1'b1;
                    end
                end
                OP_READ: begin
                    if (r_phase < RD_DATA_PHASES) begin
                        if (!r_phase[0]) begin
                            n_sda = 1'b0;
                            n_scl = 1'b1;
                            n_rx  = {r_rx[6:0], i_word.sda_level};
                        end else begin
                            n_scl = 1'b0;
                        end
                    end else if (r_phase == RD_ACK_SETUP) begin
                        n_scl = 1'b0;
                        n_sda = r_ack;
                    end else if (r_phase == RD_ACK_HIGH) begin
                        n_scl = 1'b1;
                    end else begin
                        n_scl = 1'b0;
                        last  = 1'b1;
                    end
                end
                default: begin
                    last = 1'b1;
                end
            endcase

            if (last) begin
                n_op    = OP_IDLE;
                n_phase = '0;
                n_sub   = SUB_SETUP;
                done    = 1'b1;
            end else begin
                n_phase = r_phase + 5'd1;
                n_sub   = (r_sub == SUB_LOW) ? SUB_SETUP : r_sub + 2'd1;
            end
        end

        o_res.scl_level    = n_scl;
        o_res.sda_pull_low = n_sda;
        o_res.busy_res     = (n_op != OP_IDLE);
        o_res.done_res     = done;
        o_res.nack_seen    = n_nack;
        o_res.read_byte    = n_rx;
    end

endmodule

// ===== src/i2c_master_bit_sequencer_unit.sv =====
// I2C master bit sequencer.
// Each input word is a command (start, stop, write byte, read byte), a tick that
// carries the sampled SDA level, or an unused code; every tick runs one bus phase of
// the armed command, and commands that arrive while a sequence is running are dropped.
// Every accepted input word produces exactly one output word that reports the SCL
// level, whether SDA is pulled low, busy, done, the last nack and the read byte.
// Input and output channels use valid and stall; a word moves on a rising edge
// where valid is high and stall is low.
// The datapath has an input register and an output register with the sequencer
// logic between them, so a word accepted into the input register moves on into the
// output register, and a new word can be accepted on every clock while the receiver
// does not stall (one word per cycle sustained).
// When the receiver stalls, the output word holds; the input register still takes
// one more word, after which o_stall rises until the output drains.
// A synchronous active-low reset empties both registers and returns the bus state
// to idle with SCL released high and SDA released.
module i2c_master_bit_sequencer_unit
    import i2cbs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    logic      r_in_vld;
    t_in_word  r_in;
    logic      r_out_vld;
    t_out_word r_out;
    t_out_word res;
    logic      out_blocked;
    logic      fire;
    logic      in_take;

    // The output register can take a new word unless it holds one that is stalled.
    assign out_blocked = r_out_vld && i_stall;
    assign fire        = r_in_vld && !out_blocked;
    assign o_stall     = r_in_vld && out_blocked;
    assign in_take     = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (!out_blocked) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_word;
        end
        if (fire) begin
            r_out <= res;
        end
    end

    // The sequencer state advances exactly when the registered word moves on.
    i2cbs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_word  (r_in),
        .o_res   (res)
    );

    assign o_valid = r_out_vld;
    assign o_word  = r_out;

endmodule

// ===== tb/i2c_master_bit_sequencer_unit_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the I2C master bit sequencer. A scoreboard class
// keeps its own copy of the bus sequencer state. It works out the pin word
// that each accepted input word should produce, and it checks every output
// word against the oldest pin word still waiting.
module i2c_master_bit_sequencer_unit_test
    import i2cbs_pkg::*;
();

    // Tracks the sequencer state, predicts pin words and checks them in order.
    class pin_word_scoreboard;
        t_op        bus_op;
        logic [4:0] phase;
        logic [7:0] tx_bits;
        logic [7:0] rx_bits;
        logic       ack_drive;
        logic       nack_q;
        logic       scl_q;
        logic       sda_q;
        t_out_word  pending_pins[$];
        int         errors;
        int         checked;

        function new();
            bus_op    = OP_IDLE;
            phase     = '0;
            tx_bits   = '0;
            rx_bits   = '0;
            ack_drive = 1'b0;
            nack_q    = 1'b0;
            scl_q     = 1'b1;
            sda_q     = 1'b0;
            errors    = 0;
            checked   = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH at output word %0d: %s", checked, msg);
            errors++;
        endtask

        // Runs one bus phase of the armed command. Returns 1 on its last phase.
        function bit run_bus_phase(input logic level);
            logic [1:0] slot;
            slot = 2'(phase % 3);
            case (bus_op)
                OP_START: begin
                    if (phase == 5'd0) begin
                        scl_q = 1'b1;
                        sda_q = 1'b0;
                        return 1'b0;
                    end
                    if (phase == 5'd1) begin
                        sda_q = 1'b1;
                        return 1'b0;
                    end
                    scl_q = 1'b0;
                    return 1'b1;
                end
                OP_STOP: begin
                    if (phase == 5'd0) begin
                        scl_q = 1'b0;
                        sda_q = 1'b1;
                        return 1'b0;
                    end
                    if (phase == 5'd1) begin
                        scl_q = 1'b1;
                        return 1'b0;
                    end
                    sda_q = 1'b0;
                    return 1'b1;
                end
                OP_WRITE: begin
                    if (phase < WR_DATA_PHASES) begin
                        if (slot == SUB_SETUP) begin
                            scl_q = 1'b0;
                            sda_q = ~tx_bits[7];
                        end else if (slot == SUB_HIGH) begin
                            scl_q = 1'b1;
                        end else begin
                            scl_q   = 1'b0;
                            tx_bits = {tx_bits[6:0], 1'b0};
                        end
                        return 1'b0;
                    end
                    if (phase == WR_ACK_SETUP) begin
                        scl_q = 1'b0;
                        sda_q = 1'b0;
                        return 1'b0;
                    end
                    if (phase == WR_ACK_SAMPLE) begin
                        scl_q  = 1'b1;
                        nack_q = level;
                        return 1'b0;
                    end
                    scl_q = 1'b0;
                    return 1'b1;
                end
                OP_READ: begin
                    if (phase < RD_DATA_PHASES) begin
                        if (!phase[0]) begin
                            sda_q   = 1'b0;
                            scl_q   = 1'b1;
                            rx_bits = {rx_bits[6:0], level};
                        end else begin
                            scl_q = 1'b0;
                        end
                        return 1'b0;
                    end
                    if (phase == RD_ACK_SETUP) begin
                        scl_q = 1'b0;
                        sda_q = ack_drive;
                        return 1'b0;
                    end
                    if (phase == RD_ACK_HIGH) begin
                        scl_q = 1'b1;
                        return 1'b0;
                    end
                    scl_q = 1'b0;
                    return 1'b1;
                end
                default: return 1'b1;
            endcase
        endfunction

        // Applies one accepted input word and queues the pin word it causes.
        function void take_request(input t_in_word w);
            t_out_word pins;
            logic      fin;
            fin = 1'b0;
            if (w.req_type >= REQ_START && w.req_type <= REQ_READ) begin
                if (bus_op == OP_IDLE) begin
                    bus_op = t_op'(w.req_type);
                    phase  = '0;
                    if (w.req_type == REQ_WRITE) begin
                        tx_bits = w.tx_byte;
                    end
                    if (w.req_type == REQ_READ) begin
                        ack_drive = w.send_ack;
                        rx_bits   = '0;
                    end
                end
            end else if (w.req_type == REQ_TICK && bus_op != OP_IDLE) begin
                if (run_bus_phase(w.sda_level)) begin
                    bus_op = OP_IDLE;
                    phase  = '0;
                    fin    = 1'b1;
                end else begin
                    phase = phase + 5'd1;
                end
            end
            pins.scl_level    = scl_q;
            pins.sda_pull_low = sda_q;
            pins.busy_res     = (bus_op != OP_IDLE);
            pins.done_res     = fin;
            pins.nack_seen    = nack_q;
            pins.read_byte    = rx_bits;
            pending_pins.push_back(pins);
        endfunction

        // Compares one output word with the oldest waiting pin word.
        task check_pins(input t_out_word got);
            t_out_word want;
            if (pending_pins.size() == 0) begin
                report_mismatch("output word with nothing expected");
            end else begin
                want = pending_pins.pop_front();
                if (got.scl_level !== want.scl_level)
                    report_mismatch($sformatf("scl_level got %0b want %0b",
                                              got.scl_level, want.scl_level));
                if (got.sda_pull_low !== want.sda_pull_low)
                    report_mismatch($sformatf("sda_pull_low got %0b want %0b",
                                              got.sda_pull_low, want.sda_pull_low));
                if (got.busy_res !== want.busy_res)
                    report_mismatch($sformatf("busy_res got %0b want %0b",
                                              got.busy_res, want.busy_res));
                if (got.done_res !== want.done_res)
                    report_mismatch($sformatf("done_res got %0b want %0b",
                                              got.done_res, want.done_res));
                if (got.nack_seen !== want.nack_seen)
                    report_mismatch($sformatf("nack_seen got %0b want %0b",
                                              got.nack_seen, want.nack_seen));
                if (got.read_byte !== want.read_byte)
                    report_mismatch($sformatf("read_byte got %02h want %02h",
                                              got.read_byte, want.read_byte));
            end
            checked++;
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_word  i_word;
    logic      o_valid;
    logic      i_stall;
    t_out_word o_word;

    pin_word_scoreboard sb;

    // Words accepted so far. The receiver uses this count to time its long hold.
    int words_sent    = 0;
    // While this is nonzero the sender offers words back to back.
    int burst_left    = 0;
    bit pressure_done = 1'b0;

    i2c_master_bit_sequencer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    // The clock has a 12 ns period. Inputs move on the falling edge, so they
    // are stable well before the rising edge that samples them.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // The monitor runs at the rising edge and sees the values from before the
    // edge. An input word counts as accepted when valid is high and o_stall is
    // low. An output word counts when o_valid is high and i_stall is low.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.take_request(i_word);
            end
            if (o_valid && !i_stall) begin
                sb.check_pins(o_word);
            end
        end
    end

    // Picks the idle time before the next word. Most gaps are zero or short, a
    // few are long, and now and then a burst runs with no gaps at all.
    function automatic int pick_gap();
        int n;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        n = $urandom_range(0, 99);
        if (n < 4) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (n < 55) return 0;
        if (n < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Builds a word with the given request code. The other fields are random,
    // so every bit of them takes both values whether or not it is used.
    function automatic t_in_word make_word(input logic [2:0] req);
        t_in_word w;
        w.req_type  = req;
        w.tx_byte   = 8'($urandom);
        w.send_ack  = 1'($urandom);
        w.sda_level = 1'($urandom);
        return w;
    endfunction

    // Number of ticks that a command needs to run to its done phase.
    function automatic int ticks_for(input logic [2:0] req);
        case (req)
            REQ_WRITE: return int'(WR_ACK_SAMPLE) + 2;
            REQ_READ:  return int'(RD_ACK_HIGH) + 2;
            default:   return 3;
        endcase
    endfunction

    // Offers one word and holds it until the block accepts it. Call this at a
    // falling edge. It returns at the falling edge after the acceptance, with
    // valid still high, so that back-to-back words never drop valid.
    task automatic send_word(input t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_word  = w;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        words_sent++;
        @(negedge i_clk);
    endtask

    // The receiver stalls at random: free runs, short stalls and a few long
    // ones. Once, after a few hundred words, it holds off for a long stretch.
    // The sender keeps offering words during that stretch, so the block fills
    // up and has to stall its input.
    initial begin : receiver
        int  n;
        int  len;
        logic hold;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            n = $urandom_range(0, 99);
            if (!pressure_done && words_sent >= 300) begin
                pressure_done = 1'b1;
                hold = 1'b1;
                len  = 120;
            end else if (n < 55) begin
                hold = 1'b0;
                len  = $urandom_range(1, 24);
            end else if (n < 93) begin
                hold = 1'b1;
                len  = $urandom_range(1, 3);
            end else begin
                hold = 1'b1;
                len  = $urandom_range(8, 40);
            end
            for (int c = 0; c < len; c++) begin
                @(negedge i_clk);
                i_stall = hold;
            end
        end
    end

    // The slowest correct run is about 2000 words, each waiting out a long
    // sender gap and a long receiver stall. A limit of
    // 10 ms gives several times that.
    initial begin : watchdog
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int       len;
        int       n;
        logic [2:0] cmd;
        t_in_word w;

        sb      = new();
        i_valid = 1'b0;
        i_word  = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. It covers a tick on an idle bus, the unknown request
        // codes, a full start, a command dropped while busy, a full stop and
        // an unknown code while a sequence is running.
        send_word(make_word(REQ_TICK));
        send_word(make_word(3'd5));
        send_word(make_word(3'd6));
        send_word(make_word(3'd7));
        send_word(make_word(REQ_START));
        send_word(make_word(REQ_WRITE));
        repeat (3) send_word(make_word(REQ_TICK));
        send_word(make_word(REQ_STOP));
        send_word(make_word(3'd7));
        send_word(make_word(REQ_READ));
        repeat (3) send_word(make_word(REQ_TICK));

        // Random part. Most of it is whole command sequences with random
        // content. The rest is noise: ticks while idle, unknown codes,
        // commands dropped while busy, and sequences cut short so that the
        // next command finds the bus still busy.
        while (words_sent < 1950) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(make_word(3'($urandom_range(5, 7))));
            end
            if ($urandom_range(0, 14) == 0) begin
                send_word(make_word(REQ_TICK));
            end

            n = $urandom_range(0, 9);
            if (n < 2)      cmd = REQ_START;
            else if (n < 4) cmd = REQ_STOP;
            else if (n < 7) cmd = REQ_WRITE;
            else            cmd = REQ_READ;

            w = make_word(cmd);
            if (cmd == REQ_WRITE) begin
                n = $urandom_range(0, 9);
                if (n == 0)      w.tx_byte = 8'h00;
                else if (n == 1) w.tx_byte = 8'hFF;
            end
            send_word(w);

            len = ticks_for(cmd);
            if ($urandom_range(0, 11) == 0) begin
                len = $urandom_range(0, len - 1);
            end
            for (int t = 0; t < len; t++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_word(make_word(3'($urandom_range(1, 7))));
                end
                send_word(make_word(REQ_TICK));
            end
        end
        i_valid = 1'b0;

        // Drain. Wait until every expected word has arrived, then keep waiting
        // so that any stray output word shows up.
        while (sb.pending_pins.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.pending_pins.size() != 0) begin
            sb.report_mismatch("expected output words left over");
        end

        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
